### rtl/afv_pkg.sv
`default_nettype none
package afv_pkg;

    localparam int NUM_W = 28;
    localparam int DEN_W = 14;
    localparam int QUO_W = 14;

    localparam logic [1:0] ASPECT_NATIVE  = 2'd0;
    localparam logic [1:0] ASPECT_4_3     = 2'd1;
    localparam logic [1:0] ASPECT_STRETCH = 2'd2;

    localparam logic SCALE_FIT   = 1'b0;
    localparam logic SCALE_WHOLE = 1'b1;

    localparam logic CFG_ASPECT = 1'b0;
    localparam logic CFG_SCALE  = 1'b1;

    // everything an item carries down the pipeline
    typedef struct packed {
        logic [11:0] sw;
        logic [11:0] sh;
        logic [13:0] aw;
        logic [13:0] ah;
        logic [1:0]  am;
        logic        sm;
        logic        zero;
        logic [25:0] pa;
        logic [25:0] pb;
        logic [15:0] sn;
        logic [13:0] sd;
        logic [13:0] k;
        logic [27:0] pn;
        logic [29:0] bnsn;
        logic [15:0] bdsd;
        logic [13:0] h;
        logic [25:0] hn;
        logic [26:0] awad;
        logic [25:0] skw;
        logic        sat3;
        logic [13:0] w;
        logic [30:0] lhs;
    } t_item;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] low;
        logic [QUO_W-1:0] quo;
        logic [DEN_W-1:0] den;
    } t_dstage;

endpackage
`default_nettype wire

### rtl/afv_div.sv
`default_nettype none
module afv_div #(
    parameter int SIDE_W = 1
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_stall,
    input  wire [afv_pkg::NUM_W-1:0] i_num,
    input  wire [afv_pkg::DEN_W-1:0] i_den,
    input  wire [SIDE_W-1:0]        i_side,
    output logic                    o_valid,
    input  wire                     i_stall,
    output logic [afv_pkg::QUO_W-1:0] o_quo,
    output logic [SIDE_W-1:0]       o_side
);
    import afv_pkg::*;

    // restoring division, one quotient bit per stage; quotient must fit QUO_W bits
    t_dstage           r_d    [QUO_W];
    logic [SIDE_W-1:0] r_side [QUO_W];
    logic              r_v    [QUO_W];
    logic [QUO_W:0]    w_en;

    assign w_en[QUO_W] = !i_stall;
    assign o_stall = !w_en[0];
    assign o_valid = r_v[QUO_W-1];
    assign o_quo   = r_d[QUO_W-1].quo;
    assign o_side  = r_side[QUO_W-1];

    genvar gi;
    generate
        for (gi = 0; gi < QUO_W; gi++) begin : g_stage
            t_dstage           w_src;
            t_dstage           n_d;
            logic [SIDE_W-1:0] w_side_src;
            logic              w_v_src;
            logic [DEN_W:0]    w_t;
            logic              w_ge;

            assign w_en[gi] = !r_v[gi] || w_en[gi+1];

            if (gi == 0) begin : g_first
                always_comb begin
                    w_src.rem = i_num[NUM_W-1:QUO_W];
                    w_src.low = i_num[QUO_W-1:0];
                    w_src.quo = '0;
                    w_src.den = i_den;
                end
                assign w_side_src = i_side;
                assign w_v_src    = i_valid;
            end else begin : g_rest
                assign w_src      = r_d[gi-1];
                assign w_side_src = r_side[gi-1];
                assign w_v_src    = r_v[gi-1];
            end

            always_comb begin
                w_t  = {w_src.rem, w_src.low[QUO_W-1]};
                w_ge = w_t >= {1'b0, w_src.den};
                n_d.rem = w_ge ? DEN_W'(w_t - {1'b0, w_src.den}) : w_t[DEN_W-1:0];
                n_d.low = {w_src.low[QUO_W-2:0], 1'b0};
                n_d.quo = {w_src.quo[QUO_W-2:0], w_ge};
                n_d.den = w_src.den;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[gi] <= 1'b0;
                end else if (w_en[gi]) begin
                    r_v[gi] <= w_v_src;
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_en[gi]) begin
                    r_d[gi]    <= n_d;
                    r_side[gi] <= w_side_src;
                end
            end
        end
    endgenerate

endmodule
`default_nettype wire

### rtl/aspect_fit_viewport.sv
`default_nettype none
// Centers a source picture in an available display area and reports the window offset,
// size and whole scale factor. Fully pipelined: one transaction per clock in each
// direction when not stalled. Results pass through three 14-stage restoring
// dividers (fit scale floor, window height, window width) plus the multiply/compare
// stages around them. Configuration writes take effect for transactions accepted after
// them and are expected only while the pipeline is empty.
module aspect_fit_viewport (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_index,
    input  wire  [1:0]  i_cfg_data,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [11:0] i_source_width,
    input  wire  [11:0] i_source_height,
    input  wire  [13:0] i_avail_width,
    input  wire  [13:0] i_avail_height,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [12:0] o_offset_x,
    output logic [12:0] o_offset_y,
    output logic [13:0] o_out_width,
    output logic [13:0] o_out_height,
    output logic [13:0] o_whole_scale
);
    import afv_pkg::*;

    localparam int ITEM_W = $bits(t_item);

    logic [1:0] r_aspect_mode;
    logic       r_scale_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aspect_mode <= ASPECT_NATIVE;
            r_scale_mode  <= SCALE_FIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ASPECT: r_aspect_mode <= i_cfg_data;
                CFG_SCALE:  r_scale_mode  <= i_cfg_data[0];
                default:    r_scale_mode  <= r_scale_mode;
            endcase
        end
    end

    t_item r_s0, r_s1, r_s2, r_s3, r_s4, r_s5, r_s6, r_s7, r_s8, r_s9, r_s10;
    t_item n_s0, n_s1, n_s2, n_s3, n_s4, n_s5, n_s6, n_s7, n_s8, n_s9, n_s10;
    logic  r_v0, r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9, r_v10, r_v11;
    logic  w_en0, w_en1, w_en2, w_en3, w_en4, w_en5, w_en6, w_en7;
    logic  w_en8, w_en9, w_en10, w_en11;

    logic              w_d1_stall, w_d1_valid, w_d2_stall, w_d2_valid;
    logic              w_d3_stall, w_d3_valid;
    logic [QUO_W-1:0]  w_d1_quo, w_d2_quo, w_d3_quo;
    logic [ITEM_W-1:0] w_d1_side, w_d2_side, w_d3_side;
    t_item             w_d1_item, w_d2_item, w_d3_item;
    logic [NUM_W-1:0]  w_d3_num;
    logic [DEN_W-1:0]  w_d3_den;

    logic        w_ft2, w_le2, w_ft4, w_ft6, w_ft8;
    logic [13:0] w_bn4;
    logic [11:0] w_an6, w_ad6;
    logic [13:0] w_spare_x, w_spare_y;

    logic [12:0] r_offset_x, r_offset_y;
    logic [13:0] r_out_width, r_out_height, r_whole_scale;

    // ready chain, back to front
    assign w_en11 = !r_v11 || !i_stall;
    assign w_en10 = !r_v10 || w_en11;
    assign w_en9  = !r_v9  || w_en10;
    assign w_en8  = !r_v8  || w_en9;
    assign w_en7  = !r_v7  || !w_d3_stall;
    assign w_en6  = !r_v6  || w_en7;
    assign w_en5  = !r_v5  || w_en6;
    assign w_en4  = !r_v4  || !w_d2_stall;
    assign w_en3  = !r_v3  || w_en4;
    assign w_en2  = !r_v2  || !w_d1_stall;
    assign w_en1  = !r_v1  || w_en2;
    assign w_en0  = !r_v0  || w_en1;
    assign o_stall = !w_en0;

    // capture
    always_comb begin
        n_s0      = '0;
        n_s0.sw   = i_source_width;
        n_s0.sh   = i_source_height;
        n_s0.aw   = i_avail_width;
        n_s0.ah   = i_avail_height;
        n_s0.am   = r_aspect_mode;
        n_s0.sm   = r_scale_mode;
        n_s0.zero = (i_source_width == '0) || (i_source_height == '0)
                 || (i_avail_width == '0) || (i_avail_height == '0);
    end

    // cross products for the native ratio compare
    always_comb begin
        n_s1    = r_s0;
        n_s1.pa = 26'(r_s0.aw) * 26'(r_s0.sh);
        n_s1.pb = 26'(r_s0.ah) * 26'(r_s0.sw);
    end

    // pick the limiting axis: fit scale = sn / sd
    always_comb begin
        n_s2  = r_s1;
        w_ft2 = (r_s1.am == ASPECT_4_3);
        w_le2 = w_ft2 ? ((16'(r_s1.aw) + 16'({r_s1.aw, 1'b0})) <= {r_s1.ah, 2'b00})
                      : (r_s1.pa <= r_s1.pb);
        if (!w_le2) begin
            n_s2.sn = 16'(r_s1.ah);
            n_s2.sd = 14'(r_s1.sh);
        end else if (w_ft2) begin
            n_s2.sn = 16'(r_s1.aw) + 16'({r_s1.aw, 1'b0});
            n_s2.sd = {r_s1.sh, 2'b00};
        end else begin
            n_s2.sn = 16'(r_s1.aw);
            n_s2.sd = 14'(r_s1.sw);
        end
    end

    afv_div #(.SIDE_W(ITEM_W)) u_div_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .o_stall (w_d1_stall),
        .i_num   (NUM_W'(r_s2.sn)),
        .i_den   (r_s2.sd),
        .i_side  (r_s2),
        .o_valid (w_d1_valid),
        .i_stall (!w_en3),
        .o_quo   (w_d1_quo),
        .o_side  (w_d1_side)
    );
    assign w_d1_item = w_d1_side;

    // in whole scale mode, the whole scale replaces the fit scale when it is at least one
    always_comb begin
        n_s3   = w_d1_item;
        n_s3.k = '0;
        if (w_d1_item.sm == SCALE_WHOLE && w_d1_quo != '0) begin
            n_s3.k  = w_d1_quo;
            n_s3.sn = 16'(w_d1_quo);
            n_s3.sd = 14'd1;
        end
    end

    always_comb begin
        n_s4      = r_s3;
        w_ft4     = (r_s3.am == ASPECT_4_3);
        w_bn4     = w_ft4 ? {r_s3.sh, 2'b00} : 14'(r_s3.sw);
        n_s4.pn   = 28'(r_s3.sh) * 28'(r_s3.sn);
        n_s4.bnsn = 30'(w_bn4) * 30'(r_s3.sn);
        n_s4.bdsd = w_ft4 ? (16'(r_s3.sd) + 16'({r_s3.sd, 1'b0})) : 16'(r_s3.sd);
    end

    afv_div #(.SIDE_W(ITEM_W)) u_div_height (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v4),
        .o_stall (w_d2_stall),
        .i_num   (r_s4.pn),
        .i_den   (r_s4.sd),
        .i_side  (r_s4),
        .o_valid (w_d2_valid),
        .i_stall (!w_en5),
        .o_quo   (w_d2_quo),
        .o_side  (w_d2_side)
    );
    assign w_d2_item = w_d2_side;

    always_comb begin
        n_s5   = w_d2_item;
        n_s5.h = (w_d2_quo == '0) ? 14'd1 : w_d2_quo;
    end

    always_comb begin
        n_s6      = r_s5;
        w_ft6     = (r_s5.am == ASPECT_4_3);
        w_an6     = w_ft6 ? 12'd4 : r_s5.sw;
        w_ad6     = w_ft6 ? 12'd3 : r_s5.sh;
        n_s6.hn   = 26'(r_s5.h) * 26'(w_an6);
        n_s6.awad = 27'(15'(r_s5.aw) + 15'd1) * 27'(w_ad6);
        n_s6.skw  = 26'(r_s5.sw) * 26'(r_s5.k);
    end

    // width quotient would reach past the area: clamp instead of dividing
    always_comb begin
        n_s7      = r_s6;
        n_s7.sat3 = 27'(r_s6.hn) >= r_s6.awad;
    end

    assign w_d3_num = r_s7.sat3 ? '0 : NUM_W'(r_s7.hn);
    assign w_d3_den = (r_s7.am == ASPECT_4_3) ? DEN_W'(3) : DEN_W'(r_s7.sh);

    afv_div #(.SIDE_W(ITEM_W)) u_div_width (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v7),
        .o_stall (w_d3_stall),
        .i_num   (w_d3_num),
        .i_den   (w_d3_den),
        .i_side  (r_s7),
        .o_valid (w_d3_valid),
        .i_stall (!w_en8),
        .o_quo   (w_d3_quo),
        .o_side  (w_d3_side)
    );
    assign w_d3_item = w_d3_side;

    always_comb begin
        n_s8  = w_d3_item;
        w_ft8 = (w_d3_item.am == ASPECT_4_3);
        if (!w_ft8 && w_d3_item.k != '0) begin
            n_s8.w = (w_d3_item.skw > 26'(w_d3_item.aw)) ? w_d3_item.aw
                                                          : w_d3_item.skw[13:0];
        end else if (w_d3_item.sat3) begin
            n_s8.w = w_d3_item.aw;
        end else begin
            n_s8.w = (w_d3_quo == '0) ? 14'd1 : w_d3_quo;
        end
    end

    always_comb begin
        n_s9     = r_s8;
        n_s9.lhs = 31'(15'(r_s8.w) + 15'd1) * 31'(r_s8.bdsd);
    end

    // one more pixel of width if it still fits under the ideal width
    always_comb begin
        n_s10 = r_s9;
        if (r_s9.w < r_s9.aw && r_s9.lhs <= 31'(r_s9.bnsn)) begin
            n_s10.w = r_s9.w + 14'd1;
        end
    end

    assign w_spare_x = r_s10.aw - r_s10.w;
    assign w_spare_y = r_s10.ah - r_s10.h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= 1'b0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
            r_v6  <= 1'b0;
            r_v7  <= 1'b0;
            r_v8  <= 1'b0;
            r_v9  <= 1'b0;
            r_v10 <= 1'b0;
            r_v11 <= 1'b0;
        end else begin
            if (w_en0)  r_v0  <= i_valid;
            if (w_en1)  r_v1  <= r_v0;
            if (w_en2)  r_v2  <= r_v1;
            if (w_en3)  r_v3  <= w_d1_valid;
            if (w_en4)  r_v4  <= r_v3;
            if (w_en5)  r_v5  <= w_d2_valid;
            if (w_en6)  r_v6  <= r_v5;
            if (w_en7)  r_v7  <= r_v6;
            if (w_en8)  r_v8  <= w_d3_valid;
            if (w_en9)  r_v9  <= r_v8;
            if (w_en10) r_v10 <= r_v9;
            if (w_en11) r_v11 <= r_v10;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en0)  r_s0  <= n_s0;
        if (w_en1)  r_s1  <= n_s1;
        if (w_en2)  r_s2  <= n_s2;
        if (w_en3)  r_s3  <= n_s3;
        if (w_en4)  r_s4  <= n_s4;
        if (w_en5)  r_s5  <= n_s5;
        if (w_en6)  r_s6  <= n_s6;
        if (w_en7)  r_s7  <= n_s7;
        if (w_en8)  r_s8  <= n_s8;
        if (w_en9)  r_s9  <= n_s9;
        if (w_en10) r_s10 <= n_s10;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_en11) begin
            if (r_s10.zero) begin
                r_offset_x    <= '0;
                r_offset_y    <= '0;
                r_out_width   <= '0;
                r_out_height  <= '0;
                r_whole_scale <= '0;
            end else if (r_s10.am == ASPECT_STRETCH) begin
                r_offset_x    <= '0;
                r_offset_y    <= '0;
                r_out_width   <= r_s10.aw;
                r_out_height  <= r_s10.ah;
                r_whole_scale <= '0;
            end else begin
                r_offset_x    <= w_spare_x[13:1];
                r_offset_y    <= w_spare_y[13:1];
                r_out_width   <= r_s10.w;
                r_out_height  <= r_s10.h;
                r_whole_scale <= r_s10.k;
            end
        end
    end

    assign o_valid       = r_v11;
    assign o_offset_x    = r_offset_x;
    assign o_offset_y    = r_offset_y;
    assign o_out_width   = r_out_width;
    assign o_out_height  = r_out_height;
    assign o_whole_scale = r_whole_scale;

`ifndef ASSERT_OFF
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_width) && $stable(o_out_height))
        else $error("result changed while stalled");

    a_empty_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_width == '0 |-> o_offset_x == '0 && o_whole_scale == '0)
        else $error("empty window with nonzero offset or scale");

    a_scale_height: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_whole_scale != '0 |-> o_out_height != '0 && o_out_width != '0)
        else $error("whole scale reported with empty window");

    a_stage_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v10 && !w_en10 |=> r_v10)
        else $error("stalled transaction dropped before result register");
`endif

endmodule
`default_nettype wire
